[hw/rtl/e2c_pkg.sv]
// shared types, constants and lookup functions of the epoch to calendar converter
package e2c_pkg;

    // pipeline stage positions
    localparam int unsigned S_IN    = 0;
    localparam int unsigned S_DIV   = 1;
    localparam int unsigned S_REM   = 2;
    localparam int unsigned S_DAY   = 3;
    localparam int unsigned S_SPLIT = 4;
    localparam int unsigned S_FIX   = 5;
    localparam int unsigned S_MIN   = 6;
    localparam int unsigned S_YEAR  = 7;
    localparam int unsigned S_DOYM  = 8;
    localparam int unsigned S_MP    = 9;
    localparam int unsigned S_DATE  = 10;
    localparam int unsigned S_C100  = 11;
    localparam int unsigned S_OUT   = 12;
    localparam int unsigned NSTG    = 13;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [15:0] EPOCH_WDAY    = 16'd4;
    localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
    localparam logic [17:0] DAYS_PER_CENT = 18'd36524;
    localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
    localparam logic [17:0] ERA_SHIFT     = 18'd135080;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [11:0] ERA_YEAR_LO   = 12'd1600;
    localparam logic [11:0] ERA_YEAR_HI   = 12'd2000;
    localparam logic [6:0]  YEARS_PER_CENT = 7'd100;

    // reciprocals for division by constants
    localparam logic [25:0] RECIP_675  = 26'd50903316;  // 2^35 / 675, rounded down
    localparam logic [15:0] RECIP_3600 = 16'd37283;     // 2^27 / 3600, rounded up
    localparam logic [12:0] RECIP_60   = 13'd4370;      // 2^18 / 60, rounded up
    localparam logic [16:0] RECIP_7    = 17'd74899;     // 2^19 / 7, rounded up
    localparam logic [17:0] RECIP_1460 = 18'd183861;    // 2^28 / 1460, rounded up, plus one
    localparam logic [17:0] RECIP_365  = 18'd183860;    // 2^26 / 365, rounded up
    localparam logic [10:0] RECIP_153  = 11'd1714;      // 2^18 / 153, rounded up
    localparam logic [10:0] RECIP_100  = 11'd1311;      // 2^17 / 100, rounded up

    typedef struct packed {
        logic [31:0] secs;
        logic [15:0] qday;
        logic [17:0] rem;
        logic [15:0] days;
        logic [16:0] tod;
        logic [4:0]  hour;
        logic [15:0] wx;
        logic [12:0] wq;
        logic [17:0] doe;
        logic        era_hi;
        logic [11:0] remh;
        logic [2:0]  wday;
        logic [6:0]  d1460;
        logic [2:0]  c36524;
        logic [5:0]  minute;
        logic [17:0] tyr;
        logic [5:0]  sec;
        logic [8:0]  yoe;
        logic [8:0]  doym;
        logic [3:0]  mp;
        logic [4:0]  dom;
        logic [3:0]  mon;
        logic [11:0] year;
        logic [5:0]  q100;
        logic        leap;
        logic [8:0]  doy;
    } pipe_t;

    // day offset of each month within a march-based year
    function automatic logic [8:0] march_offset(input logic [3:0] mp);
        logic [8:0] r;
        begin
            case (mp)
                4'd0:    r = 9'd0;
                4'd1:    r = 9'd31;
                4'd2:    r = 9'd61;
                4'd3:    r = 9'd92;
                4'd4:    r = 9'd122;
                4'd5:    r = 9'd153;
                4'd6:    r = 9'd184;
                4'd7:    r = 9'd214;
                4'd8:    r = 9'd245;
                4'd9:    r = 9'd275;
                4'd10:   r = 9'd306;
                4'd11:   r = 9'd337;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // days before the first of a month in a common year
    function automatic logic [8:0] days_before(input logic [3:0] mon);
        logic [8:0] r;
        begin
            case (mon)
                4'd1:    r = 9'd0;
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd59;
                4'd4:    r = 9'd90;
                4'd5:    r = 9'd120;
                4'd6:    r = 9'd151;
                4'd7:    r = 9'd181;
                4'd8:    r = 9'd212;
                4'd9:    r = 9'd243;
                4'd10:   r = 9'd273;
                4'd11:   r = 9'd304;
                4'd12:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage

[hw/rtl/epoch_to_calendar_top.sv]
// epoch seconds to civil utc date and time, pipelined converter
//
// channel   dir  width  contents
// s_axis    in   32     epoch_seconds
// m_axis    out  56     second, minute, hour, weekday, year, leap, day of year, month, day
//
// thirteen register stages, from the input register to the output register that drives m_axis_tvalid
// one transaction accepted per cycle while m_axis does not stall; every stage holds at most one item
// rst_n clears the stage valid bits only, payload registers are not reset
// a stall on m_axis freezes the whole pipeline; s_axis_tready drops with it
// the output register takes the next transaction in the cycle its own one is accepted
module epoch_to_calendar_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] epoch_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
    // [19:17] day_of_week, [31:20] calendar_year, [32] is_leap_year,
    // [41:33] day_of_year, [45:42] month_number, [50:46] day_of_month, [55:51] zero
    output logic [55:0] m_axis_tdata
);

    e2c_pkg::pipe_t st_reg  [e2c_pkg::NSTG];
    e2c_pkg::pipe_t st_next [e2c_pkg::NSTG];
    logic           valid_reg [e2c_pkg::NSTG];
    logic           adv;

    assign adv           = !valid_reg[e2c_pkg::S_OUT] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = valid_reg[e2c_pkg::S_OUT];

    always_comb
    begin
        logic [50:0] p_day;
        logic [31:0] t_rem;
        logic [32:0] p_hr;
        logic [32:0] p_wd;
        logic [17:0] doe0;
        logic [35:0] p_1460;
        logic [24:0] p_min;
        logic [35:0] p_yr;
        logic [17:0] t_doym;
        logic [1:0]  c100;
        logic [21:0] p_mp;
        logic [22:0] p_100;
        logic [11:0] r100;
        logic [8:0]  dom_t;
        e2c_pkg::pipe_t s;

        // input register
        s      = st_reg[e2c_pkg::S_IN];
        s.secs = s_axis_tdata;
        st_next[e2c_pkg::S_IN] = s;

        // day estimate: secs / 86400 = (secs >> 7) / 675
        s      = st_reg[e2c_pkg::S_IN];
        p_day  = 51'(s.secs[31:7]) * 51'(e2c_pkg::RECIP_675);
        s.qday = p_day[50:35];
        st_next[e2c_pkg::S_DIV] = s;

        // remainder of the estimate, below two days
        s      = st_reg[e2c_pkg::S_DIV];
        t_rem  = s.secs - 32'(s.qday) * 32'(e2c_pkg::SECS_PER_DAY);
        s.rem  = t_rem[17:0];
        st_next[e2c_pkg::S_REM] = s;

        // estimate may be one low
        s = st_reg[e2c_pkg::S_REM];
        if (s.rem >= 18'(e2c_pkg::SECS_PER_DAY))
        begin
            s.days = s.qday + 16'd1;
            s.tod  = 17'(s.rem - 18'(e2c_pkg::SECS_PER_DAY));
        end
        else
        begin
            s.days = s.qday;
            s.tod  = s.rem[16:0];
        end
        st_next[e2c_pkg::S_DAY] = s;

        // hour, weekday quotient, day within the 400-year era
        s      = st_reg[e2c_pkg::S_DAY];
        p_hr   = 33'(s.tod) * 33'(e2c_pkg::RECIP_3600);
        s.hour = p_hr[31:27];
        s.wx   = s.days + e2c_pkg::EPOCH_WDAY;
        p_wd   = 33'(s.wx) * 33'(e2c_pkg::RECIP_7);
        s.wq   = p_wd[31:19];
        doe0   = 18'(s.days) + e2c_pkg::ERA_SHIFT;
        s.era_hi = (doe0 >= e2c_pkg::DAYS_PER_ERA);
        s.doe  = s.era_hi ? doe0 - e2c_pkg::DAYS_PER_ERA : doe0;
        st_next[e2c_pkg::S_SPLIT] = s;

        s      = st_reg[e2c_pkg::S_SPLIT];
        s.remh = 12'(s.tod - 17'(s.hour) * 17'(e2c_pkg::SECS_PER_HOUR));
        s.wday = 3'(s.wx - 16'(s.wq) * 16'd7);
        p_1460 = 36'(s.doe) * 36'(e2c_pkg::RECIP_1460);
        s.d1460 = p_1460[34:28];
        s.c36524 = 3'(s.doe >= e2c_pkg::DAYS_PER_CENT)
                 + 3'(s.doe >= 18'(2 * 36524))
                 + 3'(s.doe >= 18'(3 * 36524))
                 + 3'(s.doe >= e2c_pkg::ERA_LAST_DAY);
        st_next[e2c_pkg::S_FIX] = s;

        s        = st_reg[e2c_pkg::S_FIX];
        p_min    = 25'(s.remh) * 25'(e2c_pkg::RECIP_60);
        s.minute = p_min[23:18];
        // drop the leap days so whole years are 365 days
        s.tyr    = s.doe - 18'(s.d1460) + 18'(s.c36524)
                 - 18'(s.doe == e2c_pkg::ERA_LAST_DAY);
        st_next[e2c_pkg::S_MIN] = s;

        s     = st_reg[e2c_pkg::S_MIN];
        s.sec = 6'(s.remh - 12'(s.minute) * 12'(e2c_pkg::SECS_PER_MIN));
        p_yr  = 36'(s.tyr) * 36'(e2c_pkg::RECIP_365);
        s.yoe = p_yr[34:26];
        st_next[e2c_pkg::S_YEAR] = s;

        s      = st_reg[e2c_pkg::S_YEAR];
        c100   = 2'(s.yoe >= 9'd100) + 2'(s.yoe >= 9'd200) + 2'(s.yoe >= 9'd300);
        t_doym = s.doe - (18'(s.yoe) * 18'(e2c_pkg::DAYS_PER_YEAR) + 18'(s.yoe[8:2])
                 - 18'(c100));
        s.doym = t_doym[8:0];
        st_next[e2c_pkg::S_DOYM] = s;

        s    = st_reg[e2c_pkg::S_DOYM];
        p_mp = (22'(s.doym) * 22'd5 + 22'd2) * 22'(e2c_pkg::RECIP_153);
        s.mp = p_mp[21:18];
        st_next[e2c_pkg::S_MP] = s;

        s     = st_reg[e2c_pkg::S_MP];
        dom_t = s.doym - e2c_pkg::march_offset(s.mp) + 9'd1;
        s.dom = dom_t[4:0];
        s.mon = (s.mp < 4'd10) ? s.mp + 4'd3 : s.mp - 4'd9;
        // january and february belong to the next civil year
        s.year = 12'(s.yoe) + (s.era_hi ? e2c_pkg::ERA_YEAR_HI : e2c_pkg::ERA_YEAR_LO)
               + 12'(s.mon <= 4'd2);
        st_next[e2c_pkg::S_DATE] = s;

        s      = st_reg[e2c_pkg::S_DATE];
        p_100  = 23'(s.year) * 23'(e2c_pkg::RECIP_100);
        s.q100 = p_100[22:17];
        st_next[e2c_pkg::S_C100] = s;

        s      = st_reg[e2c_pkg::S_C100];
        r100   = s.year - 12'(s.q100) * 12'(e2c_pkg::YEARS_PER_CENT);
        s.leap = (s.year[1:0] == 2'd0) && ((r100 != 12'd0) || (s.q100[1:0] == 2'd0));
        s.doy  = e2c_pkg::days_before(s.mon) + 9'(s.dom)
               + 9'(s.leap && (s.mon > 4'd2));
        st_next[e2c_pkg::S_OUT] = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < e2c_pkg::NSTG; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < e2c_pkg::NSTG; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < e2c_pkg::NSTG; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign m_axis_tdata = {5'd0,
                           st_reg[e2c_pkg::S_OUT].dom,
                           st_reg[e2c_pkg::S_OUT].mon,
                           st_reg[e2c_pkg::S_OUT].doy,
                           st_reg[e2c_pkg::S_OUT].leap,
                           st_reg[e2c_pkg::S_OUT].year,
                           st_reg[e2c_pkg::S_OUT].wday,
                           st_reg[e2c_pkg::S_OUT].hour,
                           st_reg[e2c_pkg::S_OUT].minute,
                           st_reg[e2c_pkg::S_OUT].sec};

`ifndef SYNTHESIS
    // corrected day split leaves less than a day of seconds
    a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[e2c_pkg::S_DAY] |-> st_reg[e2c_pkg::S_DAY].tod < e2c_pkg::SECS_PER_DAY)
        else $error("time of day out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (st_reg[e2c_pkg::S_OUT].sec < 6'd60)
                       && (st_reg[e2c_pkg::S_OUT].minute < 6'd60)
                       && (st_reg[e2c_pkg::S_OUT].hour < 5'd24)
                       && (st_reg[e2c_pkg::S_OUT].wday < 3'd7))
        else $error("time fields out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (st_reg[e2c_pkg::S_OUT].mon >= 4'd1)
                       && (st_reg[e2c_pkg::S_OUT].mon <= 4'd12)
                       && (st_reg[e2c_pkg::S_OUT].dom >= 5'd1)
                       && (st_reg[e2c_pkg::S_OUT].year >= 12'd1970)
                       && (st_reg[e2c_pkg::S_OUT].year <= 12'd2106))
        else $error("date fields out of range");

    // day of year agrees with the leap flag
    a_doy_leap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (st_reg[e2c_pkg::S_OUT].doy >= 9'd1)
                       && (st_reg[e2c_pkg::S_OUT].doy <= 9'd365 + 9'(st_reg[e2c_pkg::S_OUT].leap)))
        else $error("day of year inconsistent with leap flag");

    // a stalled output holds its transaction
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
`endif

endmodule

[test/epoch_to_calendar_top_test.sv]
`timescale 1ns / 100ps
// self-checking testbench of the epoch seconds to calendar date converter
module epoch_to_calendar_top_test;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // first member sits in the top bits, so this mirrors m_axis_tdata[50:0]
    typedef struct packed {
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [8:0]  yday;
        logic        leap;
        logic [11:0] year;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  sec;
    } civil_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] epoch_seconds
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
    // [19:17] day_of_week, [31:20] calendar_year, [32] is_leap_year,
    // [41:33] day_of_year, [45:42] month_number, [50:46] day_of_month
    logic [55:0] m_axis_tdata;

    logic [31:0] pending_instants[$];
    civil_t      calendar_due[$];
    idle_mode_t  idle_mode = IDLE_NONE;
    bit          offer_taken = 1'b0;
    int          hold_left = 0;
    int          errors = 0;

    epoch_to_calendar_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic bit is_leap(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(int unsigned m, bit leap);
        case (m)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // walks whole years, then whole months, from 1970-01-01
    function automatic civil_t civil_of(logic [31:0] secs);
        int unsigned s;
        int unsigned days_left;
        int unsigned tod;
        int unsigned y;
        int unsigned m;
        int unsigned span;
        civil_t c;
        s = secs;
        days_left = s / 86400;
        tod = s % 86400;
        c.sec = 6'(tod % 60);
        c.minute = 6'((tod / 60) % 60);
        c.hour = 5'(tod / 3600);
        // the epoch day was a thursday
        c.wday = 3'((days_left + 4) % 7);
        y = 1970;
        span = is_leap(y) ? 366 : 365;
        while (days_left >= span)
        begin
            days_left -= span;
            y++;
            span = is_leap(y) ? 366 : 365;
        end
        c.year = 12'(y);
        c.leap = is_leap(y);
        c.yday = 9'(days_left + 1);
        m = 1;
        span = month_days(m, c.leap);
        while (days_left >= span)
        begin
            days_left -= span;
            m++;
            span = month_days(m, c.leap);
        end
        c.month = 4'(m);
        c.mday = 5'(days_left + 1);
        return c;
    endfunction

    function automatic bit chance(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [31:0] random_instant();
        longint unsigned t;
        int unsigned day_pick;
        case ($urandom_range(0, 3))
            0, 1:
            begin
                return $urandom();
            end
            2:
            begin
                // first or last second of some day
                day_pick = $urandom_range(0, 49710);
                t = longint'(day_pick) * 86400 + ($urandom_range(0, 1) ? 86399 : 0);
                if (t > 64'hFFFF_FFFF)
                    t = 64'hFFFF_FFFF;
                return 32'(t);
            end
            default:
            begin
                // close to the top of the range, late 2105 to early 2106
                return 32'hFFFF_FFFF - 32'($urandom_range(0, 10_000_000));
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task automatic compare_calendar(civil_t got, civil_t want);
        if (got.sec != want.sec)
            report_mismatch("second_of_minute", 32'(got.sec), 32'(want.sec));
        if (got.minute != want.minute)
            report_mismatch("minute_of_hour", 32'(got.minute), 32'(want.minute));
        if (got.hour != want.hour)
            report_mismatch("hour_of_day", 32'(got.hour), 32'(want.hour));
        if (got.wday != want.wday)
            report_mismatch("day_of_week", 32'(got.wday), 32'(want.wday));
        if (got.year != want.year)
            report_mismatch("calendar_year", 32'(got.year), 32'(want.year));
        if (got.leap != want.leap)
            report_mismatch("is_leap_year", 32'(got.leap), 32'(want.leap));
        if (got.yday != want.yday)
            report_mismatch("day_of_year", 32'(got.yday), 32'(want.yday));
        if (got.month != want.month)
            report_mismatch("month_number", 32'(got.month), 32'(want.month));
        if (got.mday != want.mday)
            report_mismatch("day_of_month", 32'(got.mday), 32'(want.mday));
    endtask

    // input side: record each accepted transaction and its expected date
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            calendar_due.push_back(civil_of(s_axis_tdata));
            offer_taken = 1'b1;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || offer_taken))
        begin
            offer_taken = 1'b0;
            if (pending_instants.size() > 0 &&
                !chance(idle_mode == IDLE_SEND ? 62 : idle_mode == IDLE_BOTH ? 27 : 0))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_instants.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // sink ready, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !chance(idle_mode == IDLE_RECV ? 62 :
                                     idle_mode == IDLE_BOTH ? 27 : 0);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (calendar_due.size() == 0)
                report_mismatch("result with nothing pending", m_axis_tdata[31:0], 0);
            else
                compare_calendar(m_axis_tdata[50:0], calendar_due.pop_front());
        end
    end

    initial
    begin
        int phase_idx;
        int n;
        int guard;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // field extremes, day and year edges, leap days and century years
        pending_instants.push_back(32'd0);
        pending_instants.push_back(32'd1);
        pending_instants.push_back(32'd59);
        pending_instants.push_back(32'd60);
        pending_instants.push_back(32'd3599);
        pending_instants.push_back(32'd3600);
        pending_instants.push_back(32'd86399);
        pending_instants.push_back(32'd86400);
        pending_instants.push_back(32'd68169600);    // 1972-02-29
        pending_instants.push_back(32'd94608000);    // 1972-12-31, day 366
        pending_instants.push_back(32'd951782400);   // 2000-02-29
        pending_instants.push_back(32'd978307199);   // end of 2000
        pending_instants.push_back(32'd2147483647);
        pending_instants.push_back(32'd2147483648);
        pending_instants.push_back(32'd4102444799);  // end of 2099
        pending_instants.push_back(32'd4107542399);  // 2100-02-28, no leap day
        pending_instants.push_back(32'd4107542400);  // 2100-03-01
        pending_instants.push_back(32'h5555_5555);
        pending_instants.push_back(32'hAAAA_AAAA);
        pending_instants.push_back(32'hFFFF_FFFF);   // last instant, a sunday

        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            idle_mode = idle_mode_t'(phase_idx);
            for (n = 0; n < 425; n++)
                pending_instants.push_back(random_instant());
            if (idle_mode == IDLE_NONE)
            begin
                // stall the sink long enough to back the pipeline up
                while (pending_instants.size() > 300)
                    @(posedge clk);
                hold_left = 300;
            end
            while (pending_instants.size() > 0)
                @(posedge clk);
        end

        while (s_axis_tvalid)
            @(posedge clk);
        for (guard = 0; guard < 100000 && calendar_due.size() != 0; guard++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (calendar_due.size() != 0)
            report_mismatch("results missing at end", calendar_due.size(), 0);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
